@@ design/hl7_message_stream_validator_assert.svh @@
// Assertion helpers used by the checker of this block.
`ifndef HL7_MESSAGE_STREAM_VALIDATOR_ASSERT_SVH
`define HL7_MESSAGE_STREAM_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HL7V_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HL7V_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/hl7v_pkg.sv @@
package hl7v_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [7:0] MIN_HEADER_FIELDS = 8'd12;
  localparam logic [LENGTH_BITS-1:0] MIN_MESSAGE_LEN = LENGTH_BITS'(8);

  localparam logic [7:0] CHR_NUL = 8'h00;
  localparam logic [7:0] CHR_TAB = 8'h09;
  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_ESC = 8'h1B;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_BAR = 8'h7C;
  localparam logic [7:0] CHR_M = 8'h4D;
  localparam logic [7:0] CHR_S = 8'h53;
  localparam logic [7:0] CHR_H = 8'h48;

  typedef logic [LENGTH_BITS-1:0] len_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SIZE_LIMIT          = 3'd0,
    CFG_SEGMENT_LIMIT       = 3'd1,
    CFG_FIELD_LIMIT         = 3'd2,
    CFG_DROP_NULLS          = 3'd3,
    CFG_FIX_LINE_ENDS       = 3'd4,
    CFG_CHECK_HEADER_FIELDS = 3'd5
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_EMPTY         = 3'd1,
    ST_TOO_LARGE     = 3'd2,
    ST_NO_HEADER     = 3'd3,
    ST_BAD_STRUCTURE = 3'd4,
    ST_BAD_CHAR      = 3'd5,
    ST_BAD_FIELDS    = 3'd6
  } status_t;

  typedef struct packed {
    logic [23:0] size_limit;
    logic [15:0] segment_limit;
    logic [15:0] field_limit;
    logic        drop_nulls;
    logic        fix_line_ends;
    logic        check_header_fields;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    size_limit:          24'd1048576,
    segment_limit:       16'd1000,
    field_limit:         16'd1024,
    drop_nulls:          1'b1,
    fix_line_ends:       1'b1,
    check_header_fields: 1'b1
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0]  clean_byte;
    logic        clean_keep;
    logic        done_res;
    status_t     status;
    logic [23:0] error_position;
    logic [15:0] segment_total;
    logic [23:0] null_warnings;
    logic [23:0] message_length;
  } result_t;

  typedef struct packed {
    len_t        byte_counter;
    logic        length_over;
    logic [15:0] segment_counter;
    logic        segment_over;
    logic        prefix_good;
    logic        delimiter_good;
    logic        in_first_segment;
    logic [7:0]  header_field_counter;
    logic [15:0] current_field_length;
    logic [7:0]  long_field_number;
    logic        bad_char_found;
    len_t        bad_char_position;
    logic [23:0] null_counter;
    logic        previous_kept_cr;
  } msg_state_t;

  localparam msg_state_t MSG_CLEAR = '{
    byte_counter:         '0,
    length_over:          1'b0,
    segment_counter:      16'd1,
    segment_over:         1'b0,
    prefix_good:          1'b1,
    delimiter_good:       1'b1,
    in_first_segment:     1'b1,
    header_field_counter: 8'd1,
    current_field_length: 16'd0,
    long_field_number:    8'd0,
    bad_char_found:       1'b0,
    bad_char_position:    '0,
    null_counter:         24'd0,
    previous_kept_cr:     1'b0
  };

endpackage

@@ design/hl7v_if.sv @@
interface hl7v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       no_byte;
  logic       last;

  modport source (output valid, data_byte, no_byte, last, input ready);
  modport sink (input valid, data_byte, no_byte, last, output ready);
endinterface

interface hl7v_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  clean_byte;
  logic        clean_keep;
  logic        done_res;
  logic [2:0]  status;
  logic [23:0] error_position;
  logic [15:0] segment_total;
  logic [23:0] null_warnings;
  logic [23:0] message_length;

  modport source (output valid, clean_byte, clean_keep, done_res, status, error_position,
                  segment_total, null_warnings, message_length, input ready);
  modport sink (input valid, clean_byte, clean_keep, done_res, status, error_position,
                segment_total, null_warnings, message_length, output ready);
endinterface

@@ design/hl7v_cfg.sv @@
module hl7v_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [hl7v_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [hl7v_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  output hl7v_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= hl7v_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (hl7v_pkg::cfg_index_t'(cfg_index))
        hl7v_pkg::CFG_SIZE_LIMIT: begin
          cfg.size_limit <= cfg_wdata[23:0];
        end
        hl7v_pkg::CFG_SEGMENT_LIMIT: begin
          cfg.segment_limit <= cfg_wdata[15:0];
        end
        hl7v_pkg::CFG_FIELD_LIMIT: begin
          cfg.field_limit <= cfg_wdata[15:0];
        end
        hl7v_pkg::CFG_DROP_NULLS: begin
          cfg.drop_nulls <= cfg_wdata[0];
        end
        hl7v_pkg::CFG_FIX_LINE_ENDS: begin
          cfg.fix_line_ends <= cfg_wdata[0];
        end
        hl7v_pkg::CFG_CHECK_HEADER_FIELDS: begin
          cfg.check_header_fields <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/hl7v_core.sv @@
module hl7v_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  hl7v_pkg::cfg_t    cfg,
  input  hl7v_pkg::item_t   item,
  output hl7v_pkg::result_t result
);

  hl7v_pkg::msg_state_t msg_state;
  hl7v_pkg::msg_state_t msg_state_next;
  hl7v_pkg::msg_state_t upd;
  logic [7:0]           b;
  hl7v_pkg::len_t       pos;
  logic [16:0]          field_len_inc;
  logic                 ctrl_char;
  logic                 strip_null;
  logic                 keep;
  logic [7:0]           cb;
  hl7v_pkg::status_t    verdict;
  logic [23:0]          err_pos;

  assign b = item.data_byte;
  assign pos = msg_state.byte_counter;
  assign field_len_inc = {1'b0, msg_state.current_field_length} + 17'd1;
  assign ctrl_char = (b < hl7v_pkg::CHR_TAB) ||
                     ((b > hl7v_pkg::CHR_CR) && (b < hl7v_pkg::CHR_SPACE) &&
                      (b != hl7v_pkg::CHR_ESC));
  assign strip_null = (b == hl7v_pkg::CHR_NUL) && cfg.drop_nulls;

  // Fold one byte into the message state.
  always_comb begin
    upd = msg_state;
    keep = 1'b1;
    cb = b;
    if (!item.no_byte) begin
      if (((pos == hl7v_pkg::len_t'(0)) && (b != hl7v_pkg::CHR_M)) ||
          ((pos == hl7v_pkg::len_t'(1)) && (b != hl7v_pkg::CHR_S)) ||
          ((pos == hl7v_pkg::len_t'(2)) && (b != hl7v_pkg::CHR_H))) begin
        upd.prefix_good = 1'b0;
      end
      if ((pos == hl7v_pkg::len_t'(3)) && (b != hl7v_pkg::CHR_BAR)) begin
        upd.delimiter_good = 1'b0;
      end

      if (msg_state.in_first_segment && (b != hl7v_pkg::CHR_CR)) begin
        if (b == hl7v_pkg::CHR_BAR) begin
          if (msg_state.header_field_counter != 8'hFF) begin
            upd.header_field_counter = msg_state.header_field_counter + 8'd1;
          end
          upd.current_field_length = 16'd0;
        end else begin
          if ((field_len_inc > {1'b0, cfg.field_limit}) &&
              (msg_state.long_field_number == 8'd0)) begin
            upd.long_field_number = msg_state.header_field_counter;
          end
          upd.current_field_length = field_len_inc[16] ? 16'hFFFF : field_len_inc[15:0];
        end
      end

      if (b == hl7v_pkg::CHR_CR) begin
        upd.in_first_segment = 1'b0;
        if (msg_state.segment_counter == 16'hFFFF) begin
          upd.segment_over = 1'b1;
        end else begin
          upd.segment_counter = msg_state.segment_counter + 16'd1;
        end
      end

      if (ctrl_char) begin
        if (strip_null) begin
          if (msg_state.null_counter != 24'hFFFFFF) begin
            upd.null_counter = msg_state.null_counter + 24'd1;
          end
        end else if (!msg_state.bad_char_found) begin
          upd.bad_char_found = 1'b1;
          upd.bad_char_position = pos;
        end
      end

      // A dropped null leaves the CR-LF tracking untouched.
      if (strip_null) begin
        keep = 1'b0;
      end else if ((b == hl7v_pkg::CHR_LF) && cfg.fix_line_ends) begin
        if (msg_state.previous_kept_cr) begin
          keep = 1'b0;
        end else begin
          cb = hl7v_pkg::CHR_CR;
        end
        upd.previous_kept_cr = 1'b0;
      end else begin
        upd.previous_kept_cr = (b == hl7v_pkg::CHR_CR);
      end

      if (msg_state.byte_counter == '1) begin
        upd.length_over = 1'b1;
      end else begin
        upd.byte_counter = msg_state.byte_counter + hl7v_pkg::len_t'(1);
      end
    end
  end

  // Verdict in order of precedence, taken from the state after this byte.
  always_comb begin
    verdict = hl7v_pkg::ST_OK;
    err_pos = 24'd0;
    if ((upd.byte_counter == '0) && !upd.length_over) begin
      verdict = hl7v_pkg::ST_EMPTY;
    end else if (upd.length_over || (upd.byte_counter > cfg.size_limit)) begin
      verdict = hl7v_pkg::ST_TOO_LARGE;
    end else if ((upd.byte_counter < hl7v_pkg::MIN_MESSAGE_LEN) || !upd.prefix_good) begin
      verdict = hl7v_pkg::ST_NO_HEADER;
    end else if (!upd.delimiter_good) begin
      verdict = hl7v_pkg::ST_BAD_STRUCTURE;
    end else if (upd.segment_over || (upd.segment_counter > cfg.segment_limit)) begin
      verdict = hl7v_pkg::ST_BAD_STRUCTURE;
    end else if (upd.bad_char_found) begin
      verdict = hl7v_pkg::ST_BAD_CHAR;
      err_pos = upd.bad_char_position;
    end else if (cfg.check_header_fields) begin
      if (upd.header_field_counter < hl7v_pkg::MIN_HEADER_FIELDS) begin
        verdict = hl7v_pkg::ST_BAD_FIELDS;
      end else if (upd.long_field_number != 8'd0) begin
        verdict = hl7v_pkg::ST_BAD_FIELDS;
        err_pos = {16'd0, upd.long_field_number};
      end
    end
  end

  always_comb begin
    result = '0;
    result.status = hl7v_pkg::ST_OK;
    if (!item.no_byte) begin
      result.clean_byte = cb;
      result.clean_keep = keep;
    end
    if (item.last) begin
      result.done_res = 1'b1;
      result.status = verdict;
      result.error_position = err_pos;
      result.segment_total = upd.segment_counter;
      result.null_warnings = upd.null_counter;
      result.message_length = upd.byte_counter;
    end
    msg_state_next = item.last ? hl7v_pkg::MSG_CLEAR : upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_state <= hl7v_pkg::MSG_CLEAR;
    end else if (advance) begin
      msg_state <= msg_state_next;
    end
  end

endmodule

@@ design/hl7_message_stream_validator.sv @@
// Byte stream validator and sanitizer for HL7 messages. It takes one byte per
// transaction on msg and gives one transaction on res for every one it takes, after
// the input register and then the result register, and while res is not stalled it
// sustains one byte per clock cycle: the message state in the core is updated by a
// single step of compares and counter increments between the input register and
// the result register. The verdict fields are valid only when done_res is high, on
// the item marked last; otherwise they read zero. Configuration writes on cfg_we
// take effect at once and should be made only while no message is in flight.
module hl7_message_stream_validator (
  input  logic                                 clk,
  input  logic                                 rst,
  hl7v_in_if.sink                              msg,
  hl7v_out_if.source                           res,
  input  logic                                 cfg_we,
  input  logic [hl7v_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [hl7v_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  hl7v_pkg::cfg_t    cfg;
  hl7v_pkg::item_t   in_item;
  hl7v_pkg::result_t core_res;
  hl7v_pkg::result_t out_res;
  logic              in_valid;
  logic              out_valid;
  logic              advance;
  logic              take;

  assign advance = in_valid && (!out_valid || res.ready);
  assign msg.ready = !in_valid || advance;
  assign take = msg.valid && msg.ready;

  hl7v_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hl7v_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .item    (in_item),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item <= '{data_byte: msg.data_byte, no_byte: msg.no_byte, last: msg.last};
    end
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign res.valid = out_valid;
  assign res.clean_byte = out_res.clean_byte;
  assign res.clean_keep = out_res.clean_keep;
  assign res.done_res = out_res.done_res;
  assign res.status = out_res.status;
  assign res.error_position = out_res.error_position;
  assign res.segment_total = out_res.segment_total;
  assign res.null_warnings = out_res.null_warnings;
  assign res.message_length = out_res.message_length;

endmodule

@@ design/hl7v_checker.sv @@
`include "hl7_message_stream_validator_assert.svh"

module hl7v_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  clean_byte,
  input logic        clean_keep,
  input logic        done_res,
  input logic [2:0]  status,
  input logic [23:0] error_position,
  input logic [15:0] segment_total,
  input logic [23:0] null_warnings,
  input logic [23:0] message_length
);

  logic [100:0] res_payload;
  logic         res_stall;
  logic         verdict_clear;
  logic         empty_seen;
  logic         empty_shape;
  logic         ok_seen;
  logic         ok_shape;

  assign res_payload = {clean_byte, clean_keep, done_res, status, error_position,
                        segment_total, null_warnings, message_length};
  assign res_stall = res_valid && !res_ready;
  assign verdict_clear = (status == hl7v_pkg::ST_OK) && (error_position == 24'd0) &&
                         (segment_total == 16'd0) && (null_warnings == 24'd0) &&
                         (message_length == 24'd0);
  assign empty_seen = res_valid && done_res && (status == hl7v_pkg::ST_EMPTY);
  assign empty_shape = (message_length == 24'd0) && (segment_total == 16'd1) &&
                       (null_warnings == 24'd0);
  assign ok_seen = res_valid && done_res && (status == hl7v_pkg::ST_OK);
  assign ok_shape = (message_length >= hl7v_pkg::MIN_MESSAGE_LEN) &&
                    (segment_total != 16'd0) && (error_position == 24'd0);

  `HL7V_ASSERT_NEXT(a_res_hold, res_stall, res_valid && $stable(res_payload), "result changed")
  `HL7V_ASSERT_SAME(a_verdict_zero, res_valid && !done_res, verdict_clear, "early verdict")
  `HL7V_ASSERT_SAME(a_empty_len, empty_seen, empty_shape, "empty verdict with counted bytes")
  `HL7V_ASSERT_SAME(a_ok_len, ok_seen, ok_shape, "ok verdict on a message that cannot pass")

endmodule

bind hl7_message_stream_validator hl7v_checker u_hl7v_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .clean_byte     (res.clean_byte),
  .clean_keep     (res.clean_keep),
  .done_res       (res.done_res),
  .status         (res.status),
  .error_position (res.error_position),
  .segment_total  (res.segment_total),
  .null_warnings  (res.null_warnings),
  .message_length (res.message_length)
);
